>>> rtl/ucp_pkg.sv
// shared types, character codes and helper functions for the url percent codec
package ucp_pkg;

    // one input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    // one decoded byte travelling from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_dec_item;

    // queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // character codes
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_US    = 8'h5F;
    localparam logic [7:0] CHAR_SP    = 8'h20;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_UZ    = 8'h5A;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] CHAR_LZ    = 8'h7A;

    // true hex digit in either case
    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_UA && c <= CHAR_UF) ||
               (c >= CHAR_LA && c <= CHAR_LF);
    endfunction

    // value of a hex digit, zero for anything else
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] diff;
        diff = 8'd0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            diff = c - CHAR_0;
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            diff = c - CHAR_UA + 8'd10;
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            diff = c - CHAR_LA + 8'd10;
        end
        return diff[3:0];
    endfunction

    // ascii letter or digit
    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_UA && c <= CHAR_UZ) ||
               (c >= CHAR_LA && c <= CHAR_LZ);
    endfunction

    // upper-case hex character for a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] ch;
        if (v < 4'd10) begin
            ch = CHAR_0 + {4'd0, v};
        end else begin
            ch = CHAR_UA + {4'd0, v} - 8'd10;
        end
        return ch;
    endfunction

endpackage

>>> rtl/url_percent_codec.sv
// Streaming URL percent decoder and re-encoder. Bytes enter on the input channel, one per
// cycle while the front end's three-byte decode buffer and the queue behind it have room,
// and leave through a single output register at one byte per cycle while it is not stalled.
// A failed escape releases up to three decoded bytes, and in encode mode each byte that
// becomes %XX leaves as three characters, so the sustained input rate is set by the output
// register. The first output byte passes through the decode buffer, the queue and the
// output register. The user must write the mode register only while the block is idle;
// the block itself does not enforce it.
module url_percent_codec import ucp_pkg::*; #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    logic      r_mode;
    logic      w_push;
    logic      w_pop;
    t_dec_item w_push_item;
    t_dec_item w_head;
    t_q_stat   w_q_stat;

    // mode register, 1 decodes only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    // escape tracking and decode
    ucp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_item      (i_item),
        .o_stall     (o_stall),
        .o_push      (w_push),
        .o_push_item (w_push_item),
        .i_q_stat    (w_q_stat)
    );

    // decoded byte queue
    ucp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_stat      (w_q_stat)
    );

    // re-encode and output
    ucp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode   (r_mode),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .o_item   (o_item),
        .i_stall  (i_stall)
    );

`ifndef SYNTHESIS
    // front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("push into full queue");

    // back never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from empty queue");

    // a popped byte always reaches the output register next cycle
    a_pop_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_valid)
        else $error("popped byte lost");
`endif

endmodule

>>> rtl/ucp_front.sv
// front end: accepts raw bytes, tracks escapes and queues decoded bytes
module ucp_front import ucp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_stall,
    output logic      o_push,
    output t_dec_item o_push_item,
    input  t_q_stat   i_q_stat
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_PCT   = 3'b010,
        PH_DIGIT = 3'b100
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held;
    logic [1:0] r_cnt, n_cnt;
    logic [7:0] r_buf [3];
    logic [7:0] n_buf [3];
    logic       r_blast;

    logic       w_accept;
    logic       w_take_ok;
    logic [7:0] w_pbyte;
    logic       w_pemit;
    logic       w_pesc;

    // pending decoded bytes drain one per cycle into the queue while the queue is not full
    assign o_push              = (r_cnt != 2'd0) && !i_q_stat.full;
    assign o_push_item.data    = r_buf[0];
    assign o_push_item.last    = r_blast && (r_cnt == 2'd1);

    // take a new byte once the buffer is empty or about to be
    assign w_take_ok = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_push);
    assign o_stall   = !w_take_ok;
    assign w_accept  = i_valid && w_take_ok;

    // plain byte handling with no escape pending
    always_comb begin
        w_pbyte = i_item.in_byte;
        w_pemit = 1'b1;
        w_pesc  = 1'b0;
        if (i_item.in_byte == CHAR_US) begin
            w_pbyte = CHAR_SP;
        end else if (i_item.in_byte == CHAR_PCT && !i_item.in_last) begin
            w_pemit = 1'b0;
            w_pesc  = 1'b1;
        end
    end

    // escape state machine and decoded byte list
    always_comb begin
        n_phase  = w_pesc ? PH_PCT : PH_IDLE;
        n_cnt    = {1'b0, w_pemit};
        n_buf[0] = w_pbyte;
        n_buf[1] = w_pbyte;
        n_buf[2] = w_pbyte;
        unique case (r_phase)
            PH_PCT: begin
                if (is_hex(i_item.in_byte) && !i_item.in_last) begin
                    n_phase = PH_DIGIT;
                    n_cnt   = 2'd0;
                end else begin
                    n_buf[0] = CHAR_PCT;
                    n_cnt    = 2'd1 + {1'b0, w_pemit};
                end
            end
            PH_DIGIT: begin
                if (is_hex(i_item.in_byte)) begin
                    n_phase  = PH_IDLE;
                    n_buf[0] = {hex_value(r_held), hex_value(i_item.in_byte)};
                    n_cnt    = 2'd1;
                end else begin
                    n_buf[0] = CHAR_PCT;
                    n_buf[1] = r_held;
                    n_cnt    = 2'd2 + {1'b0, w_pemit};
                end
            end
            default: begin
                n_phase = w_pesc ? PH_PCT : PH_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= 2'd0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end else if (o_push) begin
            r_cnt   <= r_cnt - 2'd1;
        end
    end

    // decoded byte buffer and held digit
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_buf   <= n_buf;
            r_blast <= i_item.in_last;
            if (r_phase == PH_PCT) begin
                r_held <= i_item.in_byte;
            end
        end else if (o_push) begin
            r_buf[0] <= r_buf[1];
            r_buf[1] <= r_buf[2];
        end
    end

endmodule

>>> rtl/ucp_fifo.sv
// short queue of decoded bytes between front and back end
module ucp_fifo import ucp_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_dec_item i_push_item,
    input  logic      i_pop,
    output t_dec_item o_head,
    output t_q_stat   o_stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_dec_item     r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

endmodule

>>> rtl/ucp_back.sv
// back end: re-encodes decoded bytes and drives the output register
module ucp_back import ucp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_mode,
    input  t_dec_item i_head,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    logic       r_ov;
    t_out_item  r_out;
    logic [1:0] r_rem_cnt;
    logic [7:0] r_rem_hi, r_rem_lo;
    logic       r_rem_last;

    logic       w_load;
    logic       w_pass;

    assign o_valid = r_ov;
    assign o_item  = r_out;

    // output register can take a new byte
    assign w_load = !r_ov || !i_stall;
    assign o_pop  = w_load && (r_rem_cnt == 2'd0) && !i_q_stat.empty;

    // byte goes out as one character
    assign w_pass = i_mode || (i_head.data == CHAR_SP) || (i_head.data == CHAR_DOT) ||
                    (i_head.data == CHAR_COLON) || (i_head.data == CHAR_DASH) ||
                    (i_head.data == CHAR_US) || is_alnum(i_head.data);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov      <= 1'b0;
            r_rem_cnt <= 2'd0;
        end else if (w_load) begin
            if (r_rem_cnt != 2'd0) begin
                r_ov      <= 1'b1;
                r_rem_cnt <= r_rem_cnt - 2'd1;
            end else if (o_pop) begin
                r_ov      <= 1'b1;
                r_rem_cnt <= w_pass ? 2'd0 : 2'd2;
            end else begin
                r_ov      <= 1'b0;
            end
        end
    end

    // output byte and pending hex digits
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_rem_cnt != 2'd0) begin
                r_out.out_byte <= (r_rem_cnt == 2'd2) ? r_rem_hi : r_rem_lo;
                r_out.out_last <= r_rem_last && (r_rem_cnt == 2'd1);
            end else if (o_pop) begin
                if (w_pass) begin
                    r_out.out_byte <= (!i_mode && i_head.data == CHAR_SP) ? CHAR_US
                                                                          : i_head.data;
                    r_out.out_last <= i_head.last;
                end else begin
                    r_out.out_byte <= CHAR_PCT;
                    r_out.out_last <= 1'b0;
                end
                r_rem_hi   <= hex_char(i_head.data[7:4]);
                r_rem_lo   <= hex_char(i_head.data[3:0]);
                r_rem_last <= i_head.last;
            end
        end
    end

endmodule
